>>> hw/rtl/fifo_writeback_block_cache_tags_defines.svh
// Assertion macros shared by the cache tag engine modules.
// Depends on nothing; included by modules that assert.
`ifndef FIFO_WRITEBACK_BLOCK_CACHE_TAGS_DEFINES_SVH
`define FIFO_WRITEBACK_BLOCK_CACHE_TAGS_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define FWBC_ASSERT_IMPL(label, clk_s, rst_s, cond, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence in the following cycle.
`define FWBC_ASSERT_NEXT(label, clk_s, rst_s, cond, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fwbc_pkg.sv
// Shared types and constants of the cache tag engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fwbc_pkg;
    localparam int SLOTS_DEF  = 64;
    localparam int DEV_W      = 4;
    localparam int SECTOR_W   = 48;
    localparam int SLOT_W     = 6;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // capture request
        logic lookup;   // register match result
        logic access;   // apply read/write update and build result
        logic scan;     // examine the slot under the scan index
        logic scan_clr; // reset scan index
        logic out_load; // load the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_hit;   // current scanned slot needs writeback
        logic scan_end;   // current scanned slot is the final one
        logic any_found;  // a flush has reported at least one slot
    } sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/fifo_writeback_block_cache_tags.sv
// Top level of the cache tag engine: joins controller and datapath.
// Depends on fwbc_pkg, fwbc_ctrl and fwbc_dpath.
//
//  channel | direction | handshake         | fields
//  in      | sink      | in_valid/in_stall   | func dev all_devices sector
//  out     | source    | out_valid/out_stall | hit slot fetch writeback wb_dev wb_sector last
//
// Read or write: one beat, built in the lookup and then the access state after acceptance;
// the access state waits while the output is stalled, and the next request waits for idle.
// Flush: the scan state examines the slots in index order, then the done state closes the walk;
// the scan holds at a dirty slot while the output is stalled; the walk is set by the single scan index.
// Reset clears valid and dirty flags and the victim pointer at once; no clearing pass.
// A stalled output beat holds; no request is taken while the engine is busy or while
// the final beat of the previous request is held stalled.
`timescale 1ns / 1ps
`default_nettype none
module fifo_writeback_block_cache_tags
    import fwbc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          func,
    input  wire logic [DEV_W-1:0]    dev,
    input  wire logic                all_devices,
    input  wire logic [SECTOR_W-1:0] sector,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     hit,
    output logic [SLOT_W-1:0]        slot,
    output logic                     fetch,
    output logic                     writeback,
    output logic [DEV_W-1:0]         wb_dev,
    output logic [SECTOR_W-1:0]      wb_sector,
    output logic                     last
);
    cmd_t cmd;
    sts_t sts;

    fwbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_func   (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_last  (last),
        .cmd       (cmd),
        .sts       (sts)
    );

    fwbc_dpath #(.SLOTS(SLOTS)) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_func   (func),
        .in_dev    (dev),
        .in_all    (all_devices),
        .in_sector (sector),
        .hit       (hit),
        .slot      (slot),
        .fetch     (fetch),
        .writeback (writeback),
        .wb_dev    (wb_dev),
        .wb_sector (wb_sector),
        .last      (last)
    );
endmodule
`default_nettype wire

>>> hw/rtl/fwbc_dpath.sv
// Datapath of the cache tag engine: tag store, compare, victim pointer, output register.
// Depends on fwbc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_writeback_block_cache_tags_defines.svh"
module fwbc_dpath
    import fwbc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic [1:0]          in_func,
    input  wire logic [DEV_W-1:0]    in_dev,
    input  wire logic                in_all,
    input  wire logic [SECTOR_W-1:0] in_sector,
    output logic                     hit,
    output logic [SLOT_W-1:0]        slot,
    output logic                     fetch,
    output logic                     writeback,
    output logic [DEV_W-1:0]         wb_dev,
    output logic [SECTOR_W-1:0]      wb_sector,
    output logic                     last
);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0]    valid_reg;
    logic [SLOTS-1:0]    dirty_reg;
    logic [DEV_W-1:0]    tag_dev_reg    [SLOTS];
    logic [SECTOR_W-1:0] tag_sector_reg [SLOTS];
    logic [IDX_W-1:0]    victim_reg;
    logic [IDX_W-1:0]    scan_reg;
    logic                found_reg;

    logic [1:0]          func_reg;
    logic [DEV_W-1:0]    dev_reg;
    logic                all_reg;
    logic [SECTOR_W-1:0] sector_reg;

    logic                match_hit_reg;
    logic [IDX_W-1:0]    match_idx_reg;

    // Compare request against every slot
    logic [SLOTS-1:0] match_vec;
    logic             match_any;
    logic [IDX_W-1:0] match_idx;
    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            match_vec[i] = valid_reg[i] && (tag_dev_reg[i] == dev_reg)
                           && (tag_sector_reg[i] == sector_reg);
        end
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
        end
    end

    // Flag slots the flush has to report; look ahead for any beyond the scan index
    logic [SLOTS-1:0] flush_vec;
    logic             more_after;
    always_comb
    begin
        more_after = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            flush_vec[i] = valid_reg[i] && dirty_reg[i]
                           && (all_reg || tag_dev_reg[i] == dev_reg);
            if (flush_vec[i] && (IDX_W'(i) > scan_reg))
                more_after = 1'b1;
        end
    end

    // Scan status
    logic scan_hit;
    logic scan_end;
    assign scan_hit = flush_vec[scan_reg];
    assign scan_end = (scan_reg == IDX_W'(SLOTS - 1));
    assign sts = '{scan_hit: scan_hit, scan_end: scan_end, any_found: found_reg};

    // Capture request and compare result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= in_func;
            dev_reg    <= in_dev;
            all_reg    <= in_all;
            sector_reg <= in_sector;
        end
        if (cmd.lookup)
        begin
            match_hit_reg <= match_any;
            match_idx_reg <= match_idx;
        end
    end

    // Tag store payload
    always_ff @(posedge clk)
    begin
        if (cmd.access && !match_hit_reg)
        begin
            tag_dev_reg[victim_reg]    <= dev_reg;
            tag_sector_reg[victim_reg] <= sector_reg;
        end
    end

    // Control state: valid, dirty, pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            dirty_reg  <= '0;
            victim_reg <= '0;
            scan_reg   <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.access)
            begin
                if (match_hit_reg)
                begin
                    if (func_reg == FUNC_WRITE)
                        dirty_reg[match_idx_reg] <= 1'b1;
                end
                else
                begin
                    valid_reg[victim_reg] <= 1'b1;
                    dirty_reg[victim_reg] <= (func_reg == FUNC_WRITE);
                    victim_reg <= (victim_reg == IDX_W'(SLOTS - 1)) ? '0 : victim_reg + 1'b1;
                end
            end
            if (cmd.scan_clr)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (scan_hit)
                begin
                    dirty_reg[scan_reg] <= 1'b0;
                    found_reg <= 1'b1;
                end
                if (!scan_end)
                    scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.access)
            begin
                hit       <= match_hit_reg;
                slot      <= SLOT_W'(match_hit_reg ? match_idx_reg : victim_reg);
                fetch     <= !match_hit_reg && (func_reg == FUNC_READ);
                writeback <= !match_hit_reg && dirty_reg[victim_reg];
                wb_dev    <= (!match_hit_reg && dirty_reg[victim_reg])
                             ? tag_dev_reg[victim_reg] : '0;
                wb_sector <= (!match_hit_reg && dirty_reg[victim_reg])
                             ? tag_sector_reg[victim_reg] : '0;
                last      <= 1'b1;
            end
            else if (scan_hit)
            begin
                hit       <= 1'b0;
                slot      <= SLOT_W'(scan_reg);
                fetch     <= 1'b0;
                writeback <= 1'b1;
                wb_dev    <= tag_dev_reg[scan_reg];
                wb_sector <= tag_sector_reg[scan_reg];
                last      <= !more_after;
            end
            else
            begin
                hit       <= 1'b0;
                slot      <= '0;
                fetch     <= 1'b0;
                writeback <= 1'b0;
                wb_dev    <= '0;
                wb_sector <= '0;
                last      <= 1'b1;
            end
        end
    end

    `FWBC_ASSERT_IMPL(a_dirty_valid, clk, rst_n, 1'b1, (dirty_reg & ~valid_reg) == '0, "dirty slot not valid")
    `FWBC_ASSERT_IMPL(a_one_match, clk, rst_n, 1'b1, $onehot0(match_vec), "several slots match one tag")
    `FWBC_ASSERT_NEXT(a_scan_clean, clk, rst_n, cmd.scan && !cmd.scan_clr && scan_hit, !dirty_reg[$past(scan_reg)], "flushed slot still dirty")
endmodule
`default_nettype wire

>>> hw/rtl/fwbc_ctrl.sv
// Controller of the cache tag engine: request sequencing and output handshake.
// Depends on fwbc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_writeback_block_cache_tags_defines.svh"
module fwbc_ctrl
    import fwbc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] in_func,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire logic       out_last,
    output cmd_t            cmd,
    input  wire sts_t       sts
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_ACCESS,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   is_flush_reg, is_flush_next;

    logic in_fire, out_free;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_last && out_stall);

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        is_flush_next  = is_flush_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_func != FUNC_NONE)
                begin
                    cmd.load      = 1'b1;
                    cmd.scan_clr  = 1'b1;
                    is_flush_next = (in_func == FUNC_FLUSH);
                    state_next    = (in_func == FUNC_FLUSH) ? ST_SCAN : ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                if (out_free)
                begin
                    cmd.access     = 1'b1;
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    if (out_free)
                    begin
                        cmd.scan       = 1'b1;
                        cmd.out_load   = 1'b1;
                        out_valid_next = 1'b1;
                        if (sts.scan_end)
                            state_next = ST_DONE;
                    end
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (sts.scan_end)
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Close the walk; send an empty final beat when nothing was dirty
                if (sts.any_found)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            is_flush_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            is_flush_reg  <= is_flush_next;
        end
    end

    assign out_valid = out_valid_reg;

    `FWBC_ASSERT_IMPL(a_idle_accept, clk, rst_n, in_fire, state_reg == ST_IDLE, "beat taken while busy")
    `FWBC_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_load, out_free, "output overwritten")
    `FWBC_ASSERT_IMPL(a_flush_scan, clk, rst_n, state_reg == ST_SCAN, is_flush_reg, "scan outside flush")
endmodule
`default_nettype wire
